// ===== rtl/ptt_pkg.sv =====
`default_nettype none

package ptt_pkg;

  localparam int NUM_SLOTS_DEF = 16'h10;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_DEL  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_NOP  = 2'd3;

  localparam logic [2:0] ST_DUE      = 3'd0;
  localparam logic [2:0] ST_ADDED    = 3'd1;
  localparam logic [2:0] ST_UPDATED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;
  localparam logic [2:0] ST_REPEAT   = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REARM,
    S_FINISH
  } state_t;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } unit_op_t;

  typedef struct packed {
    logic [32:0] sum;
    logic        eq;
  } unit_res_t;

  typedef struct packed {
    logic [31:0] task_id;
    logic [30:0] period;
    logic [31:0] deadline;
  } slot_entry_t;

endpackage

`default_nettype wire

// ===== rtl/ptt_ram.sv =====
`default_nettype none

module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ptt_unit.sv =====
`default_nettype none

module ptt_unit
  import ptt_pkg::*;
(
  input  wire unit_op_t    op,
  input  wire logic [31:0] add_a,
  input  wire logic [31:0] add_b,
  input  wire logic [31:0] eq_a,
  input  wire logic [31:0] eq_b,
  output unit_res_t        res
);

  logic        sub;
  logic [32:0] ext_a;
  logic [32:0] ext_b;

  // Subtraction is signed and one bit wider, so bit 32 is the true sign.
  always_comb begin
    sub     = (op == OP_SUB);
    ext_a   = {sub & add_a[31], add_a};
    ext_b   = {sub & add_b[31], add_b} ^ {33{sub}};
    res.sum = ext_a + ext_b + {32'd0, sub};
    res.eq  = (eq_a == eq_b);
  end

endmodule

`default_nettype wire

// ===== rtl/periodic_task_timer_table_top.sv =====
// Periodic task timer table with a configurable number of slots.
// Input words arrive on in_*: in_tuser is the mode (add, delete, tick scan),
// in_tdata carries the task id, period, first delay and the current tick.
// Results leave on out_*: out_tuser is the status, out_tlast marks the final
// result of one input word, out_tdata carries task id, slot and lateness.
// The table is swept one slot per cycle, save for a rearm step at each due slot
// and output stalls, through a slot memory with one read and one write port and
// one shared add/subtract and compare unit. An add with a zero id and a repeated
// tick value skip the sweep and go straight to their final result. The next word
// is taken only after the final result of the last one has been registered.
// in_tready is high only while the sequencer is idle.
// Results pass through one output register; when the receiver stalls, the
// sweep pauses at the next due slot or at the final result until the register
// is taken. Reset marks every slot free at once through per-slot valid flags
// and clears the last seen tick to zero; no clearing pass is needed.
`default_nettype none

module periodic_task_timer_table_top
  import ptt_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // task_id[31:0], period[62:32], delay_ticks[93:63], tick_now[125:94], zero pad
  input  wire logic [127:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // task_id_res[31:0], slot_index[35:32], elapsed[67:36], zero pad
  output logic      [71:0]  out_tdata,
  // status[2:0]
  output logic      [2:0]   out_tuser,
  output logic              out_tlast
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  state_t state_r, state_nxt;

  logic [1:0]  req_mode_r, req_mode_nxt;
  logic [31:0] req_id_r, req_id_nxt;
  logic [30:0] req_per_r, req_per_nxt;
  logic [30:0] req_dly_r, req_dly_nxt;
  logic [31:0] req_tick_r, req_tick_nxt;
  logic        skip_r, skip_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic        hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic        free_r, free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [31:0] el_r, el_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] pend_id_r, pend_id_nxt;
  logic [3:0]  pend_slot_r, pend_slot_nxt;
  logic [31:0] pend_el_r, pend_el_nxt;
  logic [31:0] last_tick_r, last_tick_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [31:0] out_id_r, out_id_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [31:0] out_el_r, out_el_nxt;
  logic        out_last_r, out_last_nxt;

  logic [1:0]  in_mode;
  logic [31:0] in_id;
  logic [30:0] in_per;
  logic [30:0] in_dly;
  logic [31:0] in_tick;
  logic        in_acc;
  logic        out_free;

  unit_op_t    u_op;
  logic [31:0] u_add_a;
  logic [31:0] u_add_b;
  logic [31:0] u_eq_a;
  logic [31:0] u_eq_b;
  unit_res_t   u_res;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  slot_entry_t                ram_wentry;
  logic [IW-1:0]              ram_raddr;
  logic [$bits(slot_entry_t)-1:0] ram_rdata;
  slot_entry_t                rd;

  logic slot_valid;
  logic matched;
  logic due;
  logic rearm_go;

  assign in_mode = in_tuser;
  assign in_id   = in_tdata[31:0];
  assign in_per  = in_tdata[62:32];
  assign in_dly  = in_tdata[93:63];
  assign in_tick = in_tdata[125:94];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_el_r, out_slot_r, out_id_r};

  assign rd         = slot_entry_t'(ram_rdata);
  assign slot_valid = valid_r[idx_r];
  assign matched    = slot_valid && u_res.eq;
  assign due        = (req_mode_r == MODE_TICK) && slot_valid && !u_res.sum[32];
  assign rearm_go   = !pend_r || out_free;

  ptt_unit u_unit (
    .op    (u_op),
    .add_a (u_add_a),
    .add_b (u_add_b),
    .eq_a  (u_eq_a),
    .eq_b  (u_eq_b),
    .res   (u_res)
  );

  ptt_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode != MODE_NOP)) begin
          if (((in_mode == MODE_ADD) && (in_id == 32'd0)) ||
              ((in_mode == MODE_TICK) && u_res.eq)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (due) begin
          state_nxt = S_REARM;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_FINISH;
        end
      end
      S_REARM: begin
        if (rearm_go) begin
          state_nxt = (idx_r == LAST_IDX) ? S_FINISH : S_SCAN;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    req_mode_nxt   = req_mode_r;
    req_id_nxt     = req_id_r;
    req_per_nxt    = req_per_r;
    req_dly_nxt    = req_dly_r;
    req_tick_nxt   = req_tick_r;
    skip_nxt       = skip_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    el_nxt         = el_r;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    pend_slot_nxt  = pend_slot_r;
    pend_el_nxt    = pend_el_r;
    last_tick_nxt  = last_tick_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_slot_nxt   = out_slot_r;
    out_el_nxt     = out_el_r;
    out_last_nxt   = out_last_r;
    u_op           = OP_ADD;
    u_add_a        = req_tick_r;
    u_add_b        = {1'b0, req_dly_r};
    u_eq_a         = 32'd0;
    u_eq_b         = 32'd0;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wentry     = '{task_id: req_id_r, period: req_per_r, deadline: u_res.sum[31:0]};
    ram_raddr      = idx_r;

    unique case (state_r)
      S_IDLE: begin
        u_eq_a    = in_tick;
        u_eq_b    = last_tick_r;
        ram_raddr = '0;
        if (in_acc) begin
          req_mode_nxt = in_mode;
          req_id_nxt   = in_id;
          req_per_nxt  = in_per;
          req_dly_nxt  = in_dly;
          req_tick_nxt = in_tick;
          skip_nxt     = ((in_mode == MODE_ADD) && (in_id == 32'd0)) ||
                         ((in_mode == MODE_TICK) && u_res.eq);
          idx_nxt      = '0;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          pend_nxt     = 1'b0;
          if ((in_mode == MODE_TICK) && !u_res.eq) begin
            last_tick_nxt = in_tick;
          end
        end
      end
      S_SCAN: begin
        u_op    = OP_SUB;
        u_add_a = req_tick_r;
        u_add_b = rd.deadline;
        u_eq_a  = rd.task_id;
        u_eq_b  = req_id_r;
        if (req_mode_r == MODE_ADD) begin
          if (matched) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = idx_r;
          end else if (!slot_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = idx_r;
          end
        end else if (req_mode_r == MODE_DEL) begin
          if (matched && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = idx_r;
          end
        end
        if (due) begin
          el_nxt = u_res.sum[31:0];
        end else begin
          idx_nxt   = IW'(idx_r + 1'b1);
          ram_raddr = IW'(idx_r + 1'b1);
        end
      end
      S_REARM: begin
        u_op    = OP_ADD;
        u_add_a = req_tick_r;
        u_add_b = {1'b0, rd.period};
        if (rearm_go) begin
          if (pend_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_DUE;
            out_id_nxt     = pend_id_r;
            out_slot_nxt   = pend_slot_r;
            out_el_nxt     = pend_el_r;
            out_last_nxt   = 1'b0;
          end
          pend_nxt      = 1'b1;
          pend_id_nxt   = rd.task_id;
          pend_slot_nxt = 4'(idx_r);
          pend_el_nxt   = el_r;
          ram_we        = 1'b1;
          ram_waddr     = idx_r;
          ram_wentry    = '{task_id: rd.task_id, period: rd.period,
                            deadline: u_res.sum[31:0]};
          idx_nxt       = IW'(idx_r + 1'b1);
          ram_raddr     = IW'(idx_r + 1'b1);
        end
      end
      S_FINISH: begin
        u_op    = OP_ADD;
        u_add_a = req_tick_r;
        u_add_b = {1'b0, req_dly_r};
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_id_nxt    = req_id_r;
          out_slot_nxt  = 4'd0;
          out_el_nxt    = 32'd0;
          case (req_mode_r)
            MODE_ADD: begin
              if (skip_r) begin
                out_status_nxt = ST_NOTFOUND;
                out_id_nxt     = 32'd0;
              end else if (hit_r) begin
                out_status_nxt = ST_UPDATED;
                out_slot_nxt   = 4'(hit_idx_r);
                ram_we         = 1'b1;
                ram_waddr      = hit_idx_r;
              end else if (free_r) begin
                out_status_nxt         = ST_ADDED;
                out_slot_nxt           = 4'(free_idx_r);
                ram_we                 = 1'b1;
                ram_waddr              = free_idx_r;
                valid_nxt[free_idx_r]  = 1'b1;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            MODE_DEL: begin
              if (hit_r) begin
                out_status_nxt        = ST_REMOVED;
                out_slot_nxt          = 4'(hit_idx_r);
                valid_nxt[hit_idx_r]  = 1'b0;
              end else begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            default: begin
              if (skip_r) begin
                out_status_nxt = ST_REPEAT;
                out_id_nxt     = 32'd0;
              end else if (pend_r) begin
                out_status_nxt = ST_DUE;
                out_id_nxt     = pend_id_r;
                out_slot_nxt   = pend_slot_r;
                out_el_nxt     = pend_el_r;
              end else begin
                out_status_nxt = ST_NONE;
                out_id_nxt     = 32'd0;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      last_tick_r <= 32'd0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      skip_r      <= 1'b0;
      idx_r       <= '0;
      req_mode_r  <= MODE_NOP;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      last_tick_r <= last_tick_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      skip_r      <= skip_nxt;
      idx_r       <= idx_nxt;
      req_mode_r  <= req_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_id_r     <= req_id_nxt;
    req_per_r    <= req_per_nxt;
    req_dly_r    <= req_dly_nxt;
    req_tick_r   <= req_tick_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    el_r         <= el_nxt;
    pend_id_r    <= pend_id_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_el_r    <= pend_el_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_slot_r   <= out_slot_nxt;
    out_el_r     <= out_el_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/ptt_checker.sv =====
`default_nettype none

module ptt_checker
  import ptt_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [1:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [71:0]  out_tdata,
  input wire logic [2:0]   out_tuser,
  input wire logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("Result word changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != MODE_NOP) |=> !in_tready)
    else $error("Input accepted while an earlier word is still in work.");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_DUE) |-> out_tlast)
    else $error("Status other than due must end its run.");

  a_empty_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_NONE) || (out_tuser == ST_REPEAT)) |->
      (out_tdata == 72'd0))
    else $error("No-op result carries a nonzero payload.");

endmodule

bind periodic_task_timer_table_top ptt_checker u_ptt_checker (.*);

`default_nettype wire
